/* hdl/atlb_pkg.sv */
// ----------------------------------------------------------------------------
// atlb_pkg
// Shared types and codes for the associative TLB with backing store.
// ----------------------------------------------------------------------------
package atlb_pkg;

  // Request kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Response status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_BADPAGE = 2'd2;

  // Request transaction payload
  typedef struct packed {
    logic        req_type;
    logic [7:0]  proc_id;
    logic [15:0] page;
    logic [31:0] write_value;
  } tlb_req_t;

  // Response transaction payload
  typedef struct packed {
    logic [31:0] read_value;
    logic [1:0]  status;
  } tlb_rsp_t;

  // Control flags that travel with a request along the cell chain
  typedef struct packed {
    logic vld;  // slot carries a request
    logic ok;   // page is in range
    logic hit;  // read found its key, or write already placed
  } tok_ctl_t;

endpackage

/* hdl/assoc_tlb_with_backing_store_unit.sv */
// ----------------------------------------------------------------------------
// assoc_tlb_with_backing_store_unit
// Fully associative TLB keyed by process id and page, with a byte backing
// store per page.
// ----------------------------------------------------------------------------
// Each request walks a row of ENTRIES cells, one cell per cycle while the
// row advances, then the backing store stage and the response register;
// the length of the cell row sets its latency. Requests overlap in the row,
// so one is accepted per cycle while the response side keeps up and no
// clearing pass runs, and the whole row holds while a response waits. After
// reset the backing store is cleared one entry at a time, during which no
// request is accepted.
module assoc_tlb_with_backing_store_unit import atlb_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tlb_req_t in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output tlb_rsp_t out_rsp_o
);

  localparam int PW = $clog2(ENTRIES);

  tok_ctl_t              ctl_w  [ENTRIES+1];
  tlb_req_t              req_w  [ENTRIES+1];
  logic [VALUE_BITS-1:0] hval_w [ENTRIES+1];
  logic [ENTRIES-1:0]    ent_vld;
  logic                  adv, busy;

  // Whole pipeline moves when the response register is empty or being taken
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv && !busy;

  // Chain head
  always_comb begin
    ctl_w[0].vld = in_valid_i && in_ready_o;
    ctl_w[0].ok  = (in_req_i.page < 16'(ENTRIES));
    ctl_w[0].hit = 1'b0;
    req_w[0]     = in_req_i;
    hval_w[0]    = '0;
  end

  // Row of entry cells
  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    atlb_cell #(
      .PW        (PW),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (adv),
      .ctl_i (ctl_w[k]),
      .req_i (req_w[k]),
      .hval_i(hval_w[k]),
      .ctl_o (ctl_w[k+1]),
      .req_o (req_w[k+1]),
      .hval_o(hval_w[k+1]),
      .vld_o (ent_vld[k])
    );
  end

  // Backing store and response
  atlb_store #(
    .ENTRIES   (ENTRIES),
    .VALUE_BITS(VALUE_BITS)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .ctl_i    (ctl_w[ENTRIES]),
    .req_i    (req_w[ENTRIES]),
    .hval_i   (hval_w[ENTRIES]),
    .busy_o   (busy),
    .rsp_vld_o(out_valid_o),
    .rsp_o    (out_rsp_o)
  );

  // Valid entries always form a prefix of the row
  a_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ent_vld >> 1) & ~ent_vld) == '0)
    else $error("valid entries not contiguous from entry zero");

  // Nothing accepted or emitted during the clearing pass
  a_clr_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !in_ready_o)
    else $error("request accepted during clearing pass");

  a_clr_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !out_valid_o)
    else $error("response emitted during clearing pass");

  // Status codes and value rules
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status == ST_OK || out_rsp_o.status == ST_MISS ||
                     out_rsp_o.status == ST_BADPAGE))
    else $error("undefined status code");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == ST_BADPAGE) |-> out_rsp_o.read_value == '0)
    else $error("invalid page response carries a value");

  a_miss_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == ST_MISS) |-> out_rsp_o.read_value[31:8] == '0)
    else $error("miss response wider than a byte");

endmodule

/* hdl/atlb_cell.sv */
// ----------------------------------------------------------------------------
// atlb_cell
// One TLB entry plus one slot of the request chain. The request passing
// through compares against the entry, picks up a read hit, or places a write
// (update on key match, fill when the entry is still free).
// ----------------------------------------------------------------------------
module atlb_cell import atlb_pkg::*; #(
  parameter int PW         = 6,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  tok_ctl_t              ctl_i,
  input  tlb_req_t              req_i,
  input  logic [VALUE_BITS-1:0] hval_i,
  output tok_ctl_t              ctl_o,
  output tlb_req_t              req_o,
  output logic [VALUE_BITS-1:0] hval_o,
  output logic                  vld_o
);

  logic                  vld_q;
  logic [7:0]            proc_q;
  logic [PW-1:0]         page_q;
  logic [VALUE_BITS-1:0] value_q;

  tok_ctl_t              ctl_q, ctl_d;
  tlb_req_t              req_q;
  logic [VALUE_BITS-1:0] hval_q, hval_d;

  logic match, act, is_wr, upd, fill, rd_hit;

  // Compare and decide
  always_comb begin
    match  = vld_q && (proc_q == req_i.proc_id) && (page_q == req_i.page[PW-1:0]);
    act    = en_i && ctl_i.vld && ctl_i.ok && !ctl_i.hit;
    is_wr  = (req_i.req_type == REQ_WRITE);
    upd    = act && is_wr && (match || !vld_q);
    fill   = upd && !vld_q;
    rd_hit = act && !is_wr && match;
    ctl_d     = ctl_i;
    ctl_d.hit = ctl_i.hit | upd | rd_hit;
    hval_d    = rd_hit ? value_q : hval_i;
  end

  // Entry state; filled entries stay valid (entries are a prefix of the row)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (fill) begin
      vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill) begin
      proc_q <= req_i.proc_id;
      page_q <= req_i.page[PW-1:0];
    end
    if (upd) begin
      value_q <= VALUE_BITS'(req_i.write_value);
    end
  end

  // Chain slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q  <= req_i;
      hval_q <= hval_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign req_o  = req_q;
  assign hval_o = hval_q;
  assign vld_o  = vld_q;

endmodule

/* hdl/atlb_store.sv */
// ----------------------------------------------------------------------------
// atlb_store
// Per-page backing byte store at the end of the chain, its clearing pass
// after reset, and the response register.
// ----------------------------------------------------------------------------
module atlb_store import atlb_pkg::*; #(
  parameter int ENTRIES    = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  tok_ctl_t              ctl_i,
  input  tlb_req_t              req_i,
  input  logic [VALUE_BITS-1:0] hval_i,
  output logic                  busy_o,
  output logic                  rsp_vld_o,
  output tlb_rsp_t              rsp_o
);

  localparam int PW = $clog2(ENTRIES);

  logic [7:0]            mem_q [ENTRIES];
  logic [7:0]            rdata_q;
  logic [PW-1:0]         clr_q;
  logic                  busy_q;

  tok_ctl_t              s_ctl_q;
  logic                  s_wr_q;
  logic [VALUE_BITS-1:0] s_hval_q;

  logic                  rsp_vld_q;
  tlb_rsp_t              rsp_q, rsp_d;

  logic                  we, re;
  logic [PW-1:0]         wa;
  logic [7:0]            wd;

  // Memory port selection: clearing pass owns the write port while busy
  always_comb begin
    we = busy_q || (en_i && ctl_i.vld && ctl_i.ok && (req_i.req_type == REQ_WRITE));
    wa = busy_q ? clr_q : req_i.page[PW-1:0];
    wd = busy_q ? 8'd0 : req_i.write_value[7:0];
    re = en_i && ctl_i.vld;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem_q[req_i.page[PW-1:0]];
    end
  end

  // Clearing pass, one entry per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else if (busy_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == PW'(ENTRIES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Lookup stage alongside the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_ctl_q <= '0;
    end else if (en_i) begin
      s_ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_wr_q   <= (req_i.req_type == REQ_WRITE);
      s_hval_q <= hval_i;
    end
  end

  // Response formatting
  always_comb begin
    rsp_d = '0;
    if (!s_ctl_q.ok) begin
      rsp_d.status = ST_BADPAGE;
    end else if (s_wr_q) begin
      rsp_d.status = ST_OK;
    end else if (s_ctl_q.hit) begin
      rsp_d.read_value = 32'(s_hval_q);
      rsp_d.status     = ST_OK;
    end else begin
      rsp_d.read_value = {24'd0, rdata_q};
      rsp_d.status     = ST_MISS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (en_i) begin
      rsp_vld_q <= s_ctl_q.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign busy_o    = busy_q;
  assign rsp_vld_o = rsp_vld_q;
  assign rsp_o     = rsp_q;

endmodule
